### design/sidc_pkg.sv
// ----------------------------------------------------------------------------
// sidc_pkg
// Shared types, constants and helpers for the signed integer to decimal
// character converter.
// ----------------------------------------------------------------------------
package sidc_pkg;

    localparam int VALUE_W       = 64;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 20;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W         = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // front end sequencing
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

    // one converted number waiting for the back end
    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] top_idx;
        logic [BCD_W-1:0] bcd;
    } conv_entry_t;

    // one shift-add-3 step: correct every digit, then shift in a new bit
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0] bcd_in,
        input logic             bit_in
    );
        logic [BCD_W-1:0] adj;
        adj = bcd_in;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

### design/sidc_front.sv
// ----------------------------------------------------------------------------
// sidc_front
// Accepts a signed value, takes its magnitude and converts it to packed BCD
// with a double-dabble engine working four bits per cycle.
// ----------------------------------------------------------------------------
module sidc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [sidc_pkg::VALUE_W-1:0] value,
    output logic                          q_wr_en,
    output sidc_pkg::conv_entry_t         q_wr_data,
    input  logic                          q_full
);

    sidc_pkg::front_state_t state_reg, state_next;
    logic [sidc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         neg_reg, neg_next;
    logic [sidc_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [sidc_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [sidc_pkg::BCD_W-1:0]   bcd_work;
    logic [sidc_pkg::IDX_W-1:0]   top_idx;
    logic [sidc_pkg::VALUE_W-1:0] value_u;

    assign value_u = value;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sidc_pkg::FRONT_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // four dabble steps per cycle, msb of the magnitude first
    always_comb
    begin
        bcd_work = bcd_reg;
        for (int j = 0; j < sidc_pkg::BITS_PER_STEP; j++)
        begin
            bcd_work = sidc_pkg::dabble_step(bcd_work, bin_reg[sidc_pkg::VALUE_W-1-j]);
        end
    end

    // highest nonzero digit, zero gives index 0
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < sidc_pkg::NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*sidc_pkg::DIGIT_W +: sidc_pkg::DIGIT_W] != '0)
            begin
                top_idx = sidc_pkg::IDX_W'(d);
            end
        end
    end

    assign q_wr_data.neg     = neg_reg;
    assign q_wr_data.top_idx = top_idx;
    assign q_wr_data.bcd     = bcd_reg;

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        q_wr_en    = 1'b0;
        full       = (state_reg != sidc_pkg::FRONT_IDLE);
        unique case (state_reg)
            sidc_pkg::FRONT_IDLE:
            begin
                if (push)
                begin
                    neg_next   = value_u[sidc_pkg::VALUE_W-1];
                    bin_next   = value_u[sidc_pkg::VALUE_W-1] ? (~value_u + 64'd1) : value_u;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = sidc_pkg::FRONT_CONV;
                end
            end
            sidc_pkg::FRONT_CONV:
            begin
                bcd_next  = bcd_work;
                bin_next  = {bin_reg[sidc_pkg::VALUE_W-sidc_pkg::BITS_PER_STEP-1:0],
                             {sidc_pkg::BITS_PER_STEP{1'b0}}};
                step_next = step_reg + 1'b1;
                if (step_reg == sidc_pkg::STEP_W'(sidc_pkg::CONV_STEPS - 1))
                begin
                    state_next = sidc_pkg::FRONT_PUSH;
                end
            end
            sidc_pkg::FRONT_PUSH:
            begin
                if (!q_full)
                begin
                    q_wr_en    = 1'b1;
                    state_next = sidc_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = sidc_pkg::FRONT_IDLE;
            end
        endcase
    end

endmodule

### design/sidc_queue.sv
// ----------------------------------------------------------------------------
// sidc_queue
// Two-entry queue of converted numbers between the front and back ends.
// ----------------------------------------------------------------------------
module sidc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  sidc_pkg::conv_entry_t wr_data,
    output logic                  q_full,
    input  logic                  rd_en,
    output sidc_pkg::conv_entry_t rd_data,
    output logic                  q_empty
);

    sidc_pkg::conv_entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/sidc_back.sv
// ----------------------------------------------------------------------------
// sidc_back
// Takes converted numbers from the queue and emits their characters, sign
// first and then digits most significant first, through an output register.
// ----------------------------------------------------------------------------
module sidc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sidc_pkg::conv_entry_t        q_rd_data,
    input  logic                         q_empty,
    output logic                         q_rd_en,
    output logic                         empty,
    input  logic                         pop,
    output logic [sidc_pkg::CHAR_W-1:0]  char_code,
    output logic                         last
);

    logic                         busy_reg, busy_next;
    logic                         sign_reg, sign_next;
    logic [sidc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [sidc_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sidc_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;
    logic                         out_load, emit, finishing, take;
    logic [sidc_pkg::DIGIT_W-1:0] digit;

    assign empty     = !out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    assign digit     = bcd_reg[idx_reg*sidc_pkg::DIGIT_W +: sidc_pkg::DIGIT_W];
    assign out_load  = !out_valid_reg || pop;
    assign emit      = busy_reg && out_load;
    assign finishing = emit && !sign_reg && (idx_reg == '0);
    assign take      = (!busy_reg || finishing) && !q_empty;
    assign q_rd_en   = take;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        idx_reg  <= idx_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // character sequencing and output register
    always_comb
    begin
        busy_next      = busy_reg;
        sign_next      = sign_reg;
        idx_next       = idx_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (sign_reg)
            begin
                char_next = sidc_pkg::CHAR_MINUS;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = sidc_pkg::CHAR_ZERO + {4'b0000, digit};
                last_next = (idx_reg == '0);
                idx_next  = idx_reg - 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (finishing)
        begin
            busy_next = 1'b0;
        end
        if (take)
        begin
            busy_next = 1'b1;
            sign_next = q_rd_data.neg;
            idx_next  = q_rd_data.top_idx;
            bcd_next  = q_rd_data.bcd;
        end
    end

endmodule

### design/signed_int_to_decimal_chars.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars
// Signed 64-bit integer to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Each number pushed in comes out as its decimal text, one ASCII character per
// result transfer, most significant first, with a leading '-' for negative
// values and a single '0' for zero; last marks the final character. The most
// negative value prints as -9223372036854775808. The front end accepts a
// number, converts it by double dabble at four bits a cycle and then hands it
// to the queue, waiting while the queue is full; the back end emits one
// character per cycle while results are popped, 1 to 20 per number, picks up a
// queued number on the cycle of the previous number's last character, and
// loads a number into its registers first when it had gone idle. A two-entry
// queue lets the two overlap.
module signed_int_to_decimal_chars (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sidc_pkg::VALUE_W-1:0] value,
    output logic                                empty,
    input  logic                                pop,
    output logic [sidc_pkg::CHAR_W-1:0]         char_code,
    output logic                                last
);

    sidc_pkg::conv_entry_t wr_data, rd_data;
    logic                  wr_en, q_full, rd_en, q_empty;

    // accept and convert
    sidc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .q_wr_en   (wr_en),
        .q_wr_data (wr_data),
        .q_full    (q_full)
    );

    // decoupling queue
    sidc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .q_empty (q_empty)
    );

    // character emission
    sidc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd_data (rd_data),
        .q_empty   (q_empty),
        .q_rd_en   (rd_en),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last)
    );

endmodule

### test/signed_int_to_decimal_chars_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars_tb
// Pushes signed 64-bit numbers into the converter and checks every character
// transfer against a predicted decimal text, including sign, last marker,
// zero and the most negative value, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_chars_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 150;

    // one character of expected decimal text
    typedef struct {
        logic [sidc_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_char_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic signed [sidc_pkg::VALUE_W-1:0] value = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic [sidc_pkg::CHAR_W-1:0]         char_code;
    logic                                last;

    logic [sidc_pkg::VALUE_W-1:0] numbers_to_send [$];
    text_char_t         expected_chars [$];
    logic               number_taken = 1'b0;
    logic               quiet = 1'b0;
    logic               long_hold_go = 1'b0;
    logic               long_hold_started = 1'b0;
    int                 send_gap = 0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    signed_int_to_decimal_chars dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last)
    );

    always #5 clk = ~clk;

    // decimal text of one number, appended to the expected characters
    task automatic predict_text(input logic [sidc_pkg::VALUE_W-1:0] num);
        logic [sidc_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digits [sidc_pkg::NUM_DIGITS];
        logic                         neg;
        int                           n;
        text_char_t                   ch;
        neg = num[sidc_pkg::VALUE_W-1];
        // unsigned magnitude, so the most negative value gives 2^63
        mag = neg ? (~num + 1'b1) : num;
        n = 0;
        do
        begin
            digits[n] = 4'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0 && n < sidc_pkg::NUM_DIGITS);
        if (neg)
        begin
            ch.code = sidc_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            ch.code = sidc_pkg::CHAR_ZERO + sidc_pkg::CHAR_W'(digits[i]);
            ch.last = (i == 0);
            expected_chars.push_back(ch);
        end
    endtask

    // random number: full width, or a random digit count and sign
    function automatic logic [sidc_pkg::VALUE_W-1:0] random_number();
        logic [sidc_pkg::VALUE_W-1:0] raw;
        logic [sidc_pkg::VALUE_W-1:0] scale;
        int                           ndig;
        raw = {$urandom, $urandom};
        if ($urandom_range(2) == 0)
        begin
            return raw;
        end
        ndig = $urandom_range(1, 19);
        scale = 64'd1;
        repeat (ndig) scale = scale * 10;
        raw = raw % scale;
        if ($urandom_range(1) == 1)
        begin
            raw = ~raw + 1'b1;
        end
        return raw;
    endfunction

    // transfers on both sides, sampled at the rising edge
    always @(posedge clk)
    begin : sample_proc
        text_char_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d characters outstanding", $time,
                     expected_chars.size());
            $display("signed_int_to_decimal_chars_tb NOT OK");
            $finish;
        end
        else
        begin
            number_taken <= rst_n && push && !full;
            if (rst_n && push && !full)
            begin
                predict_text(value);
            end
            if (rst_n && pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t unexpected character: expected none, got code %0d last %0b",
                             $time, char_code, last);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code)
                    begin
                        $display("%0t char_code mismatch: expected %0d, got %0d",
                                 $time, want.code, char_code);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t last mismatch: expected %0b, got %0b",
                                 $time, want.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    // sender: holds an offered number until its transfer, with random gaps
    always @(negedge clk)
    begin : send_proc
        logic                                nxt_push;
        logic signed [sidc_pkg::VALUE_W-1:0] nxt_value;
        nxt_push = push;
        nxt_value = value;
        if (rst_n && (!push || number_taken))
        begin
            nxt_push = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (numbers_to_send.size() != 0)
            begin
                if (!quiet && $urandom_range(3) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                end
                else
                begin
                    nxt_push = 1'b1;
                    nxt_value = numbers_to_send.pop_front();
                end
            end
        end
        push <= nxt_push;
        value <= nxt_value;
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin : recv_proc
        logic nxt_pop;
        nxt_pop = 1'b0;
        if (rst_n)
        begin
            if (long_hold_go && !long_hold_started)
            begin
                hold_left = LONG_HOLD;
                long_hold_started = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!quiet && $urandom_range(3) == 0)
            begin
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                nxt_pop = 1'b1;
            end
        end
        pop <= nxt_pop;
    end

    // wait until every number has gone in and every character has come out
    task automatic wait_drained();
        @(negedge clk);
        while (numbers_to_send.size() != 0 || push || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // stimulus phases
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: extremes, zero, single digits, digit-count boundaries
        numbers_to_send.push_back(64'd0);
        numbers_to_send.push_back(64'd1);
        numbers_to_send.push_back(-64'sd1);
        numbers_to_send.push_back(64'd9);
        numbers_to_send.push_back(64'd10);
        numbers_to_send.push_back(-64'sd10);
        numbers_to_send.push_back(-64'sd9);
        numbers_to_send.push_back(64'd99);
        numbers_to_send.push_back(64'd100);
        numbers_to_send.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        numbers_to_send.push_back(64'h8000_0000_0000_0000);
        numbers_to_send.push_back(64'h8000_0000_0000_0001);
        numbers_to_send.push_back(64'd999999999999999999);
        numbers_to_send.push_back(64'd1000000000000000000);
        numbers_to_send.push_back(-64'sd999999999999999999);
        numbers_to_send.push_back(-64'sd1000000000000000000);
        numbers_to_send.push_back(64'd1234567890);
        numbers_to_send.push_back(-64'sd1234567890);
        numbers_to_send.push_back(64'h5555_5555_5555_5555);
        numbers_to_send.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        numbers_to_send.push_back(64'hFFFF_FFFF_0000_0000);
        numbers_to_send.push_back(64'h0000_0000_FFFF_FFFF);
        numbers_to_send.push_back(64'd0);
        // sender pauses here until all text has come out
        wait_drained();

        // receiver holds off while numbers keep coming, so the block fills
        long_hold_go = 1'b1;
        repeat (12) numbers_to_send.push_back(random_number());
        wait_drained();

        // random bulk with idling on both sides
        repeat (100) numbers_to_send.push_back(random_number());
        wait_drained();

        // closing stretch without idling
        quiet = 1'b1;
        repeat (40) numbers_to_send.push_back(random_number());
        wait_drained();

        // catch any stray characters after the last expected one
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
        begin
            $display("signed_int_to_decimal_chars_tb OK");
        end
        else
        begin
            $display("signed_int_to_decimal_chars_tb NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
design/sidc_pkg.sv
design/sidc_front.sv
design/sidc_queue.sv
design/sidc_back.sv
design/signed_int_to_decimal_chars.sv
test/signed_int_to_decimal_chars_tb.sv
